// File: sv/minmax_rescale_to_narrow_pixels_assert.svh
// Assertion macros for the contrast stretch block.
`ifndef MINMAX_RESCALE_TO_NARROW_PIXELS_ASSERT_SVH
`define MINMAX_RESCALE_TO_NARROW_PIXELS_ASSERT_SVH
`ifndef SYNTH
`define MMR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MMR_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MMR_ASSERT(label, clk, rst, prop)
`define MMR_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: sv/mmr_pkg.sv
package mmr_pkg;
  localparam int unsigned PIXEL_CAPACITY = 4096;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CONVERT = 1'b1;
  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_SUB = 2'd1,
    MODE_SCALE = 2'd2
  } mode_t;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;
  typedef struct packed {
    logic start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

// File: sv/mmr_if.sv
interface mmr_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic signed [31:0] pixel;
  modport source(output valid, opcode, pixel, input ready);
  modport sink(input valid, opcode, pixel, output ready);
endinterface

interface mmr_out_if;
  logic valid;
  logic ready;
  logic [15:0] out_pixel;
  logic [1:0] mode_used;
  logic is_last;
  modport source(output valid, out_pixel, mode_used, is_last, input ready);
  modport sink(input valid, out_pixel, mode_used, is_last, output ready);
endinterface

// File: sv/minmax_rescale_to_narrow_pixels.sv
// Channel | Dir | Payload
// in_ch   | in  | opcode, pixel
// out_ch  | out | out_pixel, mode_used, is_last
// A load writes its pixel straight into the pixel memory. A convert passes through
// the read state, then in scale mode the divide state, which waits for the
// bit-serial divider, and then the output state before its result is registered.
// Reset is synchronous; the pixel memory holds no reset value.
// The input is held off during a convert and while a result waits in the output register.
`include "minmax_rescale_to_narrow_pixels_assert.svh"
module minmax_rescale_to_narrow_pixels #(
  parameter int unsigned PIXEL_CAPACITY = mmr_pkg::PIXEL_CAPACITY,
  localparam int unsigned AW = (PIXEL_CAPACITY > 1) ? $clog2(PIXEL_CAPACITY) : 1,
  localparam int unsigned CW = $clog2(PIXEL_CAPACITY + 1)
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic cfg_wdata,
  mmr_in_if.sink in_ch,
  mmr_out_if.source out_ch
);
  mmr_pkg::state_t state, state_next;
  logic wide;
  logic [CW-1:0] count;
  logic [CW-1:0] rpos;
  logic signed [31:0] vmin, vmax;
  logic [31:0] rdata;
  logic [15:0] res_pixel;
  logic [1:0] res_mode;
  logic res_last;
  logic res_valid;
  mmr_pkg::div_req_t dreq;
  logic dbusy;
  logic [47:0] dquot;
  logic load_ok, conv_ok, acc;
  logic signed [32:0] span;
  logic [32:0] maxv;
  logic [31:0] off;
  logic [47:0] prod;
  mmr_pkg::mode_t mode;
  logic last;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == mmr_pkg::ST_IDLE) && !res_valid;
  assign load_ok = acc && in_ch.opcode == mmr_pkg::OP_LOAD && rpos == '0 &&
                   count < CW'(PIXEL_CAPACITY);
  assign conv_ok = acc && in_ch.opcode == mmr_pkg::OP_CONVERT && count != '0;

  mmr_store #(.DEPTH(PIXEL_CAPACITY)) u_store (
    .clk(clk), .we(load_ok), .waddr(count[AW-1:0]), .wdata(in_ch.pixel),
    .raddr(rpos[AW-1:0]), .rdata(rdata)
  );

  // The divider takes off*MAX, formed by shift and subtract since MAX is 2^k - 1.
  assign prod = wide ? ({off, 16'd0} - {16'd0, off}) : ({8'd0, off, 8'd0} - {16'd0, off});

  always_comb begin
    maxv = wide ? 33'd65535 : 33'd255;
    span = 33'(vmax) - 33'(vmin);
    off = rdata - vmin;
    if (!vmin[31] && 33'(vmax) <= $signed(maxv)) begin
      mode = mmr_pkg::MODE_COPY;
    end else if (span <= $signed(maxv)) begin
      mode = mmr_pkg::MODE_SUB;
    end else begin
      mode = mmr_pkg::MODE_SCALE;
    end
    last = (rpos + CW'(1)) == count;
    dreq.start = (state == mmr_pkg::ST_READ) && mode == mmr_pkg::MODE_SCALE;
    dreq.dividend = prod;
    dreq.divisor = span[31:0];
  end

  mmr_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dquot));

  always_comb begin
    state_next = state;
    case (state)
      mmr_pkg::ST_IDLE: begin
        if (conv_ok) begin
          state_next = mmr_pkg::ST_READ;
        end
      end
      mmr_pkg::ST_READ: begin
        state_next = (mode == mmr_pkg::MODE_SCALE) ? mmr_pkg::ST_DIV : mmr_pkg::ST_OUT;
      end
      mmr_pkg::ST_DIV: begin
        if (!dbusy) begin
          state_next = mmr_pkg::ST_OUT;
        end
      end
      mmr_pkg::ST_OUT: begin
        state_next = mmr_pkg::ST_IDLE;
      end
      default: state_next = mmr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmr_pkg::ST_IDLE;
      wide <= 1'b0;
      count <= '0;
      rpos <= '0;
      res_valid <= 1'b0;
      vmin <= '0;
      vmax <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        wide <= cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        res_valid <= 1'b0;
      end
      if (load_ok) begin
        count <= count + CW'(1);
        if (count == '0 || in_ch.pixel < vmin) begin
          vmin <= in_ch.pixel;
        end
        if (count == '0 || in_ch.pixel > vmax) begin
          vmax <= in_ch.pixel;
        end
      end
      if (state == mmr_pkg::ST_READ) begin
        res_mode <= mode;
        res_last <= last;
        if (mode == mmr_pkg::MODE_COPY) begin
          res_pixel <= rdata[15:0];
        end else begin
          res_pixel <= off[15:0];
        end
      end
      if (state == mmr_pkg::ST_DIV && !dbusy) begin
        res_pixel <= dquot[15:0];
      end
      if (state == mmr_pkg::ST_OUT) begin
        res_valid <= 1'b1;
        if (res_last) begin
          count <= '0;
          rpos <= '0;
        end else begin
          rpos <= rpos + CW'(1);
        end
      end
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.out_pixel = res_pixel;
  assign out_ch.mode_used = res_mode;
  assign out_ch.is_last = res_last;

  `MMR_ASSERT(a_no_accept_busy, clk, rst, (state != mmr_pkg::ST_IDLE) |-> !in_ch.ready)
  `MMR_ASSERT(a_rpos_bound, clk, rst, (count != '0) |-> (rpos < count))
  `MMR_ASSERT(a_out_after, clk, rst, (state == mmr_pkg::ST_OUT) |=> out_ch.valid)
endmodule

// File: sv/mmr_store.sv
module mmr_store #(
  parameter int unsigned DEPTH = mmr_pkg::PIXEL_CAPACITY,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/mmr_div.sv
module mmr_div (
  input  logic clk,
  input  logic rst,
  input  mmr_pkg::div_req_t req,
  output logic busy,
  output logic [47:0] quot
);
  // Restoring division of a 48-bit dividend (32-bit value times the output
  // maximum, formed by shifts) by a 32-bit divisor, one bit per cycle.
  logic [47:0] num;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0] cnt;
  logic [32:0] trial;
  always_comb begin
    trial = {rem[31:0], num[47]} - {1'b0, dvs};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 6'd48;
      num <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      quot <= '0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        quot <= {quot[46:0], 1'b1};
      end else begin
        rem <= {rem[31:0], num[47]};
        quot <= {quot[46:0], 1'b0};
      end
      num <= {num[46:0], 1'b0};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_TARGET = 1750;

  typedef struct packed {
    logic [15:0] pix;
    mmr_pkg::mode_t mode;
    logic last;
  } pix_result_t;

  typedef struct {
    bit is_cfg;
    bit op;
    logic [31:0] px;
    bit typed;
    pix_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  mmr_in_if in_ch();
  mmr_out_if out_ch();

  minmax_rescale_to_narrow_pixels i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [31:0] img_mem [0:mmr_pkg::PIXEL_CAPACITY-1];
  int unsigned img_count;
  int unsigned img_rpos;
  longint img_min;
  longint img_max;
  bit wide_mode;

  pix_result_t expected_pixels[$];
  stim_row_t stim_rows[$];
  int errors;
  int items_done;
  int stall_cycles;
  bit quiet;

  function automatic bit rescale_step(input bit op, input logic [31:0] px,
                                      output bit has_res, output pix_result_t r);
    longint p;
    longint maxv;
    longint span;
    has_res = 1'b0;
    r = '0;
    if (op == mmr_pkg::OP_LOAD) begin
      p = longint'(signed'(px));
      if (img_rpos != 0 || img_count >= mmr_pkg::PIXEL_CAPACITY) return 1'b0;
      if (img_count == 0) begin
        img_min = p;
        img_max = p;
      end else begin
        if (p < img_min) img_min = p;
        if (p > img_max) img_max = p;
      end
      img_mem[img_count] = px;
      img_count++;
      return 1'b1;
    end
    if (img_count == 0 || img_rpos >= img_count) return 1'b0;
    maxv = wide_mode ? 65535 : 255;
    p = longint'(signed'(img_mem[img_rpos]));
    span = img_max - img_min;
    if (img_min >= 0 && img_max <= maxv) begin
      r.mode = mmr_pkg::MODE_COPY;
      r.pix = p[15:0];
    end else if (span <= maxv) begin
      r.mode = mmr_pkg::MODE_SUB;
      r.pix = 16'(p - img_min);
    end else begin
      r.mode = mmr_pkg::MODE_SCALE;
      r.pix = 16'(((p - img_min) * maxv) / span);
    end
    r.last = (img_rpos + 1 == img_count);
    if (r.last) begin
      img_count = 0;
      img_rpos = 0;
    end else begin
      img_rpos++;
    end
    has_res = 1'b1;
    return 1'b1;
  endfunction

  task automatic idle_gap();
    int g;
    if (quiet || $urandom_range(3) != 0) return;
    g = ($urandom_range(19) == 0) ? $urandom_range(80, 20) : $urandom_range(3, 1);
    in_ch.valid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_item(input bit op, input logic [31:0] px, input bit typed,
                           input pix_result_t typed_res);
    bit has_res;
    bit effect;
    pix_result_t r;
    idle_gap();
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.pixel <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    effect = rescale_step(op, px, has_res, r);
    if (effect) items_done++;
    if (has_res) expected_pixels.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input bit v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    wide_mode = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_pixel(input int cls, input logic [31:0] base);
    if ($urandom_range(9) == 0) cls = 4;
    case (cls)
      0: return $urandom_range(255);
      1: return $urandom_range(65535);
      2: return base + $urandom_range(255);
      3: return base + $urandom_range(65535);
      5: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'd0;
          default: return 32'd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_row(input bit is_cfg, input bit op, input logic [31:0] px,
                                  input bit typed, input logic [15:0] epix,
                                  input mmr_pkg::mode_t emode, input bit elast);
    stim_row_t s;
    s.is_cfg = is_cfg;
    s.op = op;
    s.px = px;
    s.typed = typed;
    s.res.pix = epix;
    s.res.mode = emode;
    s.res.last = elast;
    stim_rows.push_back(s);
  endfunction

  always @(posedge clk) begin
    int g;
    if (rst) begin
      out_ch.ready <= 1'b0;
      g = 0;
    end else if (g > 0) begin
      out_ch.ready <= 1'b0;
      g--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(3) == 0)
        g = ($urandom_range(19) == 0) ? $urandom_range(80, 20) : $urandom_range(3, 1);
    end
  end

  always @(posedge clk) begin
    pix_result_t got;
    pix_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.pix = out_ch.out_pixel;
      got.mode = mmr_pkg::mode_t'(out_ch.mode_used);
      got.last = out_ch.is_last;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected transaction: pixel %0d mode %0d last %0d",
                   got.pix, got.mode, got.last);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected pixel %0d mode %0d last %0d, got %0d %0d %0d",
                     want.pix, want.mode, want.last, got.pix, got.mode, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    int cls;
    logic [31:0] base;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= mmr_pkg::OP_LOAD;
    in_ch.pixel <= '0;
    items_done = 0;
    quiet = 1'b0;
    img_count = 0;
    img_rpos = 0;
    img_min = 0;
    img_max = 0;
    wide_mode = 1'b0;

    add_row(1, 0, 0, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 0, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 255, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 255, mmr_pkg::MODE_COPY, 1);
    add_row(0, mmr_pkg::OP_LOAD, 32'h8000_0000, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 32'h7fff_ffff, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 0, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 0, mmr_pkg::MODE_SCALE, 0);
    add_row(0, mmr_pkg::OP_LOAD, 5, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 255, mmr_pkg::MODE_SCALE, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 127, mmr_pkg::MODE_SCALE, 1);
    add_row(0, mmr_pkg::OP_LOAD, 1000, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 1255, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 0, mmr_pkg::MODE_SUB, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 255, mmr_pkg::MODE_SUB, 1);
    add_row(0, mmr_pkg::OP_LOAD, 32'hffff_fffb, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 0, mmr_pkg::MODE_SUB, 1);
    add_row(1, 1, 0, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 0, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 65535, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 65535, mmr_pkg::MODE_COPY, 1);
    add_row(0, mmr_pkg::OP_LOAD, 32'hffff_ffff, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_LOAD, 65534, 0, 0, mmr_pkg::MODE_COPY, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 0, mmr_pkg::MODE_SUB, 0);
    add_row(0, mmr_pkg::OP_CONVERT, 0, 1, 65535, mmr_pkg::MODE_SUB, 1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg)
        write_width(stim_rows[i].op);
      else
        send_item(stim_rows[i].op, stim_rows[i].px, stim_rows[i].typed, stim_rows[i].res);
    end

    items_done = 0;
    while (items_done < ITEM_TARGET) begin
      quiet = ($urandom_range(5) == 0);
      if ($urandom_range(2) == 0) write_width(~wide_mode);
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 21) : $urandom_range(20, 1);
      cls = $urandom_range(5);
      base = $urandom;
      if ($urandom_range(7) == 0) send_item(mmr_pkg::OP_CONVERT, 0, 0, '0);
      for (int k = 0; k < n; k++)
        send_item(mmr_pkg::OP_LOAD, pick_pixel(cls, base), 0, '0);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && $urandom_range(7) == 0) write_width(~wide_mode);
        if (k > 0 && $urandom_range(9) == 0) send_item(mmr_pkg::OP_LOAD, $urandom, 0, '0);
        send_item(mmr_pkg::OP_CONVERT, 0, 0, '0);
      end
      if ($urandom_range(5) == 0) send_item(mmr_pkg::OP_CONVERT, 0, 0, '0);
    end

    wait_drained();
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
